// ===== rtl/mbd_pkg.sv =====
`timescale 1ns / 1ps
package mbd_pkg;
    localparam int LANE_W = 10;
    localparam int PIX_W  = 4 * LANE_W;
    localparam int LVL_W  = 4;
    localparam int POS_W  = 11;
    localparam int DIM_W  = 13;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEVELS = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;

    // one result beat
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic [7:0]       a;
        logic             last;
    } res_t;

    // rounded quarter of each 10-bit lane, repacked
    function automatic pix_t quarter_round(input pix_t t);
        pix_t r;
        logic [LANE_W-1:0] s;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            s = t[k*LANE_W +: LANE_W] + LANE_W'(2);
            r[k*LANE_W +: LANE_W] = {2'b00, s[LANE_W-1:2]};
        end
        return r;
    endfunction

    function automatic pix_t lane_add(input pix_t a, input pix_t b);
        pix_t r;
        for (int k = 0; k < 4; k++)
            r[k*LANE_W +: LANE_W] = a[k*LANE_W +: LANE_W] + b[k*LANE_W +: LANE_W];
        return r;
    endfunction
endpackage

// ===== rtl/mipmap_box_downsample_chain.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Signals
// in        in   in_valid/in_stall, red_in green_in blue_in alpha_in
// out       out  out_valid/out_stall, mip_level pos_x pos_y *_out run_last
// apb       in   psel penable pwrite paddr pwdata prdata pready
// The back end takes a pixel from the queue while idle; each level it then
// passes goes through a line-buffer read, then an update, and each emitted
// result through the output state, held in the output register while
// out_stall is high; with no result it is idle again, with one level dropped.
// rst_n clears all counters; the line buffer is never cleared.
// A two-beat input queue lets pixels in while results are stalled.
module mipmap_box_downsample_chain
    import mbd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_LEVELS = 13
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [7:0]  alpha_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  mip_level,
    output logic [10:0] pos_x,
    output logic [10:0] pos_y,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [7:0]  alpha_out,
    output logic        run_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [LVL_W-1:0] levels_reg;
    logic wr, flush, q_valid, q_take;
    pix_t q_pix;
    res_t res;
    logic [DIM_W-1:0] w, h, m;
    logic [LVL_W-1:0] maxl, nlev;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    // any register write restarts the image
    assign flush = wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT
                          || paddr[3:2] == REG_LEVELS) && paddr[1:0] == 2'b00;

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_LEVELS: prdata = 32'(levels_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            levels_reg <= '0;
        end
        else if (flush)
        begin
            case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_LEVELS: levels_reg <= pwdata[LVL_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamp dimensions and work out the level count
    always_comb
    begin
        w = (width_reg == '0) ? DIM_W'(1) :
            (32'(width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_reg;
        h = (height_reg == '0) ? DIM_W'(1) :
            (32'(height_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : height_reg;
        m = (w < h) ? w : h;
        maxl = LVL_W'(1);
        for (int i = 1; i < DIM_W; i++)
            if (m[i]) maxl = LVL_W'(i + 1);
        nlev = (levels_reg == '0 || levels_reg > maxl) ? maxl : levels_reg;
        if (32'(nlev) > MAX_LEVELS) nlev = LVL_W'(MAX_LEVELS);
    end

    mbd_front u_front (
        .clk(clk), .rst_n(rst_n), .flush(flush),
        .in_valid(in_valid), .in_stall(in_stall),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
        .q_valid(q_valid), .q_pix(q_pix), .q_take(q_take)
    );

    mbd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_LEVELS(MAX_LEVELS)) u_back (
        .clk(clk), .rst_n(rst_n), .flush(flush),
        .w0(w), .h0(h), .nlev(nlev),
        .q_valid(q_valid), .q_pix(q_pix), .q_take(q_take),
        .res_valid(out_valid), .res(res), .res_stall(out_stall)
    );

    assign mip_level = res.level;
    assign pos_x     = res.x;
    assign pos_y     = res.y;
    assign red_out   = res.r;
    assign green_out = res.g;
    assign blue_out  = res.b;
    assign alpha_out = res.a;
    assign run_last  = res.last;
endmodule

// ===== rtl/mbd_front.sv =====
`timescale 1ns / 1ps
// Accepts pixels, packs them into lanes and holds them in a two-entry queue.
module mbd_front
    import mbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       flush,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red_in,
    input  logic [7:0] green_in,
    input  logic [7:0] blue_in,
    input  logic [7:0] alpha_in,
    output logic       q_valid,
    output pix_t       q_pix,
    input  logic       q_take
);
    pix_t q_mem_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_take;
    assign q_pix = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= {2'b00, alpha_in, 2'b00, blue_in,
                                      2'b00, green_in, 2'b00, red_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else if (flush)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== rtl/mbd_back.sv =====
`timescale 1ns / 1ps
// Walks one pixel down the levels, a buffer read then an update for each level,
// then the output state for each result handed to the output register.
module mbd_back
    import mbd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_LEVELS = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             flush,
    input  logic [DIM_W-1:0] w0,
    input  logic [DIM_W-1:0] h0,
    input  logic [LVL_W-1:0] nlev,
    input  logic             q_valid,
    input  pix_t             q_pix,
    output logic             q_take,
    output logic             res_valid,
    output res_t             res,
    input  logic             res_stall
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(MAX_LEVELS);
    localparam int CW = DIM_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    pix_t lbuf [MAX_WIDTH];
    pix_t lbuf_q_reg;
    pix_t acc_reg [MAX_LEVELS];
    logic [CW-1:0] col_reg [MAX_LEVELS];
    logic [CW-1:0] row_reg [MAX_LEVELS];

    logic [1:0] state_reg;
    logic [LW-1:0] lev_reg;
    logic [DIM_W-1:0] w_reg, h_reg;
    logic [DIM_W:0] off_reg;
    pix_t px_reg;
    res_t res_reg;
    res_t pend_reg;
    logic res_valid_reg;

    logic [CW-1:0] x, y;
    logic [DIM_W-1:0] nw, nh;
    logic inside_blk, idx_ok, more;
    logic [DIM_W:0] idx;
    pix_t ps, q;
    logic [LW-1:0] nxt_lev;
    logic [CW-1:0] nx, ny;
    logic [DIM_W-1:0] nnw, nnh;
    logic [DIM_W:0] nidx;
    logic next_made;
    logic res_load;

    assign x = col_reg[lev_reg];
    assign y = row_reg[lev_reg];
    assign nw = w_reg >> 1;
    assign nh = h_reg >> 1;
    assign inside_blk = (x < {nw, 1'b0}) && (y < {nh, 1'b0});
    assign idx = off_reg + (DIM_W+1)'(x >> 1);
    assign idx_ok = idx < (DIM_W+1)'(MAX_WIDTH);
    assign ps = lane_add(acc_reg[lev_reg], px_reg);
    assign q  = quarter_round(lane_add(lbuf_q_reg, ps));
    assign more = (32'(lev_reg) + 2 < 32'(nlev));

    // will the level below also finish a pixel with this one
    assign nxt_lev = more ? lev_reg + 1'b1 : lev_reg;
    assign nx = col_reg[nxt_lev];
    assign ny = row_reg[nxt_lev];
    assign nnw = nw >> 1;
    assign nnh = nh >> 1;
    assign nidx = off_reg + (DIM_W+1)'(nw) + (DIM_W+1)'(nx >> 1);
    assign next_made = more && nx[0] && ny[0] && (nx < {nnw, 1'b0})
                       && (ny < {nnh, 1'b0}) && (nidx < (DIM_W+1)'(MAX_WIDTH));

    assign res_load = (state_reg == S_OUT) && (!res_valid_reg || !res_stall);

    assign q_take = (state_reg == S_IDLE) && q_valid;
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
            lbuf_q_reg <= lbuf[idx[AW-1:0]];
        if (state_reg == S_UPD && inside_blk && x[0] && idx_ok && !y[0])
            lbuf[idx[AW-1:0]] <= ps;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
            lev_reg <= '0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                acc_reg[i] <= '0;
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end
        else if (flush)
        begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                acc_reg[i] <= '0;
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end
        else
        begin
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    // with a single level the pixel is simply dropped
                    if (q_take && nlev > LVL_W'(1))
                    begin
                        px_reg  <= q_pix;
                        lev_reg <= '0;
                        w_reg   <= w0;
                        h_reg   <= h0;
                        off_reg <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                    state_reg <= S_UPD;
                S_UPD:
                begin
                    if (x + 1'b1 >= w_reg)
                    begin
                        col_reg[lev_reg] <= '0;
                        row_reg[lev_reg] <= (y + 1'b1 >= h_reg) ? '0 : y + 1'b1;
                    end
                    else
                        col_reg[lev_reg] <= x + 1'b1;
                    state_reg <= S_IDLE;
                    if (inside_blk)
                    begin
                        if (!x[0])
                            acc_reg[lev_reg] <= px_reg;
                        else if (idx_ok && y[0])
                        begin
                            pend_reg.level <= LVL_W'(lev_reg) + 1'b1;
                            pend_reg.x <= POS_W'(x >> 1);
                            pend_reg.y <= POS_W'(y >> 1);
                            pend_reg.r <= q[7:0];
                            pend_reg.g <= q[LANE_W +: 8];
                            pend_reg.b <= q[2*LANE_W +: 8];
                            pend_reg.a <= q[3*LANE_W +: 8];
                            pend_reg.last <= !next_made;
                            px_reg <= q;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (res_load)
                    begin
                        res_reg <= pend_reg;
                        if (more)
                        begin
                            lev_reg <= lev_reg + 1'b1;
                            off_reg <= off_reg + (DIM_W+1)'(nw);
                            w_reg <= nw;
                            h_reg <= nh;
                            state_reg <= S_RD;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
